@@ rtl/core/nsr_pkg.sv @@
package nsr_pkg;

   localparam int RADICAND_WIDTH = 32;
   localparam int ROOT_WIDTH     = 31;
   localparam int ITER_WIDTH     = 7;
   localparam int EST_WIDTH      = 32;

   localparam logic [ITER_WIDTH-1:0] ITER_RESET = 7'd8;
   localparam logic [ROOT_WIDTH-1:0] ROOT_MAX   = {ROOT_WIDTH{1'b1}};

   typedef logic signed [RADICAND_WIDTH-1:0] radicand_type;
   typedef logic [ROOT_WIDTH-1:0]            root_type;
   typedef logic [ITER_WIDTH-1:0]            iter_type;
   typedef logic [EST_WIDTH-1:0]             est_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PREP   = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

@@ rtl/core/nsr_req_if.sv @@
interface nsr_req_if;
   logic                 valid;
   logic                 ready;
   nsr_pkg::radicand_type radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

@@ rtl/core/nsr_rsp_if.sv @@
interface nsr_rsp_if;
   logic             valid;
   logic             ready;
   nsr_pkg::root_type root;
   logic             status;

   modport source (output valid, output root, output status, input ready);
   modport sink   (input valid, input root, input status, output ready);
endinterface

@@ rtl/core/nsr_csr_if.sv @@
interface nsr_csr_if;
   logic             valid;
   logic             ready;
   nsr_pkg::iter_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/newton_square_root_unit.sv @@
// Square root of a signed fixed-point radicand (FRACTION_BITS fraction bits) by Newton
// iteration from 1.0, repeated iteration_count times (0 counts as 1, values above
// MAX_ITERATIONS clamp to it). A negative radicand skips to the finish state and returns
// status 1 and root 0. Otherwise each iteration runs a set-up step, then a restoring
// divider that retires one quotient bit per cycle over the 32+FRACTION_BITS dividend
// bits, then an averaging step. The default is Q16.16 with eight iterations. Once the
// estimate reaches zero the division is skipped. One request is worked at a time; the
// result sits in an output register, so the next request is taken while the previous
// result waits.
module newton_square_root_unit #(
   parameter int MAX_ITERATIONS = 64,
   parameter int FRACTION_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   nsr_req_if.sink   req_channel,
   nsr_rsp_if.source rsp_channel,
   nsr_csr_if.sink   csr_channel
);

   localparam int DIV_WIDTH = nsr_pkg::EST_WIDTH + FRACTION_BITS;
   localparam int BIT_CNT_W = $clog2(DIV_WIDTH);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(DIV_WIDTH - 1);
   localparam nsr_pkg::est_type ONE_FIXED = nsr_pkg::est_type'(64'd1 << FRACTION_BITS);

   nsr_pkg::state_type state_ff, state_in;
   nsr_pkg::iter_type  iter_ff, iter_in;
   nsr_pkg::iter_type  steps_ff, steps_in;
   nsr_pkg::iter_type  step_cnt_ff, step_cnt_in;
   nsr_pkg::est_type   est_ff, est_in;
   nsr_pkg::est_type   held_ff, held_in;
   nsr_pkg::est_type   quot_ff, quot_in;
   nsr_pkg::est_type   rem_ff, rem_in;
   logic [DIV_WIDTH-1:0] dividend_ff, dividend_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   nsr_pkg::root_type    rsp_root_ff, rsp_root_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                     req_take;
   logic                     csr_take;
   nsr_pkg::iter_type        steps_eff;
   logic [nsr_pkg::EST_WIDTH:0]   rem_shift;
   logic [nsr_pkg::EST_WIDTH+1:0] trial;
   logic                     quot_bit;
   nsr_pkg::est_type         quot_sat;
   logic [nsr_pkg::EST_WIDTH:0]   sum;
   nsr_pkg::iter_type        step_next;

   assign req_channel.ready = (state_ff == nsr_pkg::ST_IDLE);
   assign csr_channel.ready = 1'b1;
   assign req_take = req_channel.valid && req_channel.ready;
   assign csr_take = csr_channel.valid && csr_channel.ready;

   assign rsp_channel.valid  = rsp_valid_ff;
   assign rsp_channel.root   = rsp_root_ff;
   assign rsp_channel.status = rsp_status_ff;

   always_comb begin
      if (iter_ff == '0) begin
         steps_eff = nsr_pkg::iter_type'(1);
      end else if (int'(iter_ff) > MAX_ITERATIONS) begin
         steps_eff = nsr_pkg::iter_type'(MAX_ITERATIONS);
      end else begin
         steps_eff = iter_ff;
      end
   end

   // one restoring-division step: remainder stays below the estimate
   assign rem_shift = {rem_ff, dividend_ff[DIV_WIDTH-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, est_ff};
   assign quot_bit  = !trial[nsr_pkg::EST_WIDTH+1];

   assign quot_sat  = ovf_ff ? '1 : quot_ff;
   assign sum       = {1'b0, est_ff} + {1'b0, quot_sat};
   assign step_next = step_cnt_ff + nsr_pkg::iter_type'(1);

   always_comb begin
      state_in      = state_ff;
      iter_in       = csr_take ? csr_channel.data : iter_ff;
      steps_in      = steps_ff;
      step_cnt_in   = step_cnt_ff;
      est_in        = est_ff;
      held_in       = held_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      dividend_in   = dividend_ff;
      bit_cnt_in    = bit_cnt_ff;
      ovf_in        = ovf_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_channel.ready;
      rsp_root_in   = rsp_root_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         nsr_pkg::ST_IDLE: begin
            if (req_take) begin
               held_in     = nsr_pkg::est_type'(req_channel.radicand);
               est_in      = ONE_FIXED;
               step_cnt_in = '0;
               steps_in    = steps_eff;
               neg_in      = req_channel.radicand[nsr_pkg::RADICAND_WIDTH-1];
               state_in    = req_channel.radicand[nsr_pkg::RADICAND_WIDTH-1]
                             ? nsr_pkg::ST_FINISH : nsr_pkg::ST_PREP;
            end
         end
         nsr_pkg::ST_PREP: begin
            dividend_in = {held_ff, {FRACTION_BITS{1'b0}}};
            rem_in      = '0;
            quot_in     = '0;
            ovf_in      = 1'b0;
            bit_cnt_in  = '0;
            // zero estimate: quotient taken as zero, no division
            state_in    = (est_ff == '0) ? nsr_pkg::ST_UPDATE : nsr_pkg::ST_DIVIDE;
         end
         nsr_pkg::ST_DIVIDE: begin
            rem_in      = quot_bit ? trial[nsr_pkg::EST_WIDTH-1:0]
                                   : rem_shift[nsr_pkg::EST_WIDTH-1:0];
            quot_in     = {quot_ff[nsr_pkg::EST_WIDTH-2:0], quot_bit};
            ovf_in      = ovf_ff | quot_ff[nsr_pkg::EST_WIDTH-1];
            dividend_in = dividend_ff << 1;
            bit_cnt_in  = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = nsr_pkg::ST_UPDATE;
            end
         end
         nsr_pkg::ST_UPDATE: begin
            est_in      = sum[nsr_pkg::EST_WIDTH:1];
            step_cnt_in = step_next;
            state_in    = (step_next == steps_ff) ? nsr_pkg::ST_FINISH : nsr_pkg::ST_PREP;
         end
         nsr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = neg_ff;
               if (neg_ff) begin
                  rsp_root_in = '0;
               end else if (est_ff[nsr_pkg::EST_WIDTH-1]) begin
                  rsp_root_in = nsr_pkg::ROOT_MAX;
               end else begin
                  rsp_root_in = est_ff[nsr_pkg::ROOT_WIDTH-1:0];
               end
               state_in = nsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsr_pkg::ST_IDLE;
         iter_ff      <= nsr_pkg::ITER_RESET;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      est_ff        <= est_in;
      held_ff       <= held_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      dividend_ff   <= dividend_in;
      bit_cnt_ff    <= bit_cnt_in;
      ovf_ff        <= ovf_in;
      neg_ff        <= neg_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
